/* design/iptf_pkg.sv */
package iptf_pkg;

    // table geometry
    localparam int MAX_QUOTA     = 16;
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SPAN_W        = $clog2(TABLE_ENTRIES + 1);

    // fixed field widths
    localparam int QUOTA_W = 5;
    localparam int PAGE_W  = 20;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 32;

    localparam logic [QUOTA_W-1:0] QUOTA_RESET = QUOTA_W'(16);

    // one access
    typedef struct packed {
        logic              proc_id;
        logic [PAGE_W-1:0] page_number;
        logic              is_write;
    } iptf_in_t;

    // one result
    typedef struct packed {
        logic              hit;
        logic              flushed;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  fault_total;
        logic [CNT_W-1:0]  disk_transfers;
        logic [CNT_W-1:0]  dirty_writebacks;
    } iptf_out_t;

    // what the table memory holds per entry
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              dirty;
    } iptf_entry_t;

    // saturating add of two counter-width values
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

/* design/inverted_page_table_flush_when_full.sv */
// Inverted page table for two processes with flush-when-full replacement.
// Input channel in_valid/in_stall/in_data carries one access beat (process,
// page, read/write). Output channel out_valid/out_stall/out_data returns
// exactly one result beat per access: hit, flush flag, slot and the
// process's three saturating counters. cfg_valid/cfg_ready/cfg_data writes
// frame_quota; it is always ready. It is to be written only while the block
// idles; the user is bound to this, the block itself does not enforce it.
// Each access is handled alone: an accept in the idle state, then a scan
// that reads the page memory one entry a cycle over 2*quota entries (the
// quota clamped to 1..16), the return of the last registered read, and a
// finish state that updates the table. A hit ends the scan at its matching
// entry. The scan is serial because the page memory has a single read port.
// A new beat is accepted once the finish state has passed, even while the
// previous result still waits in the output register; the finish state waits while that register is full and stalled.
// Reset clears the valid and owner bits (flip-flops) and all counters and
// sets the quota to 16; no clearing pass over the memory is needed.
module inverted_page_table_flush_when_full (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  iptf_pkg::iptf_in_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output iptf_pkg::iptf_out_t       out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [iptf_pkg::QUOTA_W-1:0] cfg_data
);

    import iptf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [QUOTA_W-1:0] quota_reg;

    // entry flags in flip-flops
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    logic [TABLE_ENTRIES-1:0] entry_owner_reg;

    // per-process counters
    logic [QUOTA_W-1:0] fsf_reg       [2];
    logic [CNT_W-1:0]   fault_cnt_reg [2];
    logic [CNT_W-1:0]   disk_cnt_reg  [2];
    logic [CNT_W-1:0]   wb_cnt_reg    [2];

    // current access
    logic               cur_p_reg;
    logic [PAGE_W-1:0]  cur_page_reg;
    logic               cur_wr_reg;
    logic [QUOTA_W-1:0] q_reg;
    logic [SPAN_W-1:0]  span_reg;

    // scan pipeline
    logic [SPAN_W-1:0] rd_idx_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              free0_ok_reg, free1_ok_reg;
    logic [IDX_W-1:0]  free0_reg, free1_reg;
    logic [SPAN_W-1:0] dcnt_reg;

    logic      out_valid_reg;
    iptf_out_t out_data_reg;

    // memory side
    iptf_entry_t ram_q;
    iptf_entry_t ram_wdata;
    logic        ram_we;
    logic        rd_en;

    // effective quota and span of an accepted beat
    logic [QUOTA_W-1:0] q_eff;
    logic [QUOTA_W:0]   twice_q;
    logic [SPAN_W-1:0]  span_eff;

    logic in_acc;
    logic fin_go;
    logic c_valid, c_own, c_match, c_last;

    logic [QUOTA_W:0]   fsf_inc;
    logic               flush_now;
    logic               free_ok;
    logic [IDX_W-1:0]   free_sel;
    logic [CNT_W-1:0]   fault_new, disk_new, wb_new;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // quota clamp and search span
    always_comb
    begin
        q_eff = quota_reg;
        if (quota_reg == '0)
        begin
            q_eff = QUOTA_W'(1);
        end
        else if (32'(quota_reg) > MAX_QUOTA)
        begin
            q_eff = QUOTA_W'(MAX_QUOTA);
        end
        twice_q = {q_eff, 1'b0};
        if (32'(twice_q) > TABLE_ENTRIES)
        begin
            span_eff = SPAN_W'(TABLE_ENTRIES);
        end
        else
        begin
            span_eff = SPAN_W'(twice_q);
        end
    end

    // quota register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quota_reg <= QUOTA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            quota_reg <= cfg_data;
        end
    end

    // compare stage on the returned entry
    assign c_valid = entry_valid_reg[cmp_idx_reg];
    assign c_own   = (entry_owner_reg[cmp_idx_reg] == cur_p_reg);
    assign c_match = cmp_vld_reg && c_valid && c_own && (ram_q.page == cur_page_reg);
    assign c_last  = cmp_vld_reg && ((SPAN_W'(cmp_idx_reg) + SPAN_W'(1)) == span_reg);
    assign rd_en   = (state_reg == ST_SCAN) && (rd_idx_reg < span_reg);

    assign fin_go = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // miss bookkeeping
    always_comb
    begin
        fsf_inc   = {1'b0, fsf_reg[cur_p_reg]} + (QUOTA_W+1)'(1);
        flush_now = (fsf_inc >= ({1'b0, q_reg} + (QUOTA_W+1)'(1)));
        free_ok   = flush_now ? free1_ok_reg : free0_ok_reg;
        free_sel  = flush_now ? free1_reg : free0_reg;
        fault_new = sat_add(fault_cnt_reg[cur_p_reg], CNT_W'(1));
        disk_new  = flush_now ? sat_add(disk_cnt_reg[cur_p_reg], CNT_W'(q_reg))
                              : disk_cnt_reg[cur_p_reg];
        wb_new    = flush_now ? sat_add(wb_cnt_reg[cur_p_reg], CNT_W'(dcnt_reg))
                              : wb_cnt_reg[cur_p_reg];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (c_match || c_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // access capture and scan tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free0_ok_reg <= 1'b0;
            free1_ok_reg <= 1'b0;
            rd_idx_reg   <= '0;
            dcnt_reg     <= '0;
        end
        else if (in_acc)
        begin
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free0_ok_reg <= 1'b0;
            free1_ok_reg <= 1'b0;
            rd_idx_reg   <= '0;
            dcnt_reg     <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            cmp_vld_reg <= rd_en;
            if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + SPAN_W'(1);
            end
            if (c_match)
            begin
                hit_reg <= 1'b1;
            end
            if (cmp_vld_reg)
            begin
                if (!c_valid && !free0_ok_reg)
                begin
                    free0_ok_reg <= 1'b1;
                end
                if ((!c_valid || c_own) && !free1_ok_reg)
                begin
                    free1_ok_reg <= 1'b1;
                end
                if (c_valid && c_own && ram_q.dirty)
                begin
                    dcnt_reg <= dcnt_reg + SPAN_W'(1);
                end
            end
        end
        else
        begin
            cmp_vld_reg <= 1'b0;
        end
    end

    // payload of the scan, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_p_reg    <= in_data.proc_id;
            cur_page_reg <= in_data.page_number;
            cur_wr_reg   <= in_data.is_write;
            q_reg        <= q_eff;
            span_reg     <= span_eff;
        end
        if (state_reg == ST_SCAN)
        begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
            if (c_match)
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (cmp_vld_reg && !c_valid && !free0_ok_reg)
            begin
                free0_reg <= cmp_idx_reg;
            end
            if (cmp_vld_reg && (!c_valid || c_own) && !free1_ok_reg)
            begin
                free1_reg <= cmp_idx_reg;
            end
        end
    end

    // table flags and counters, updated on a miss
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            entry_owner_reg <= '0;
            for (int p = 0; p < 2; p++)
            begin
                fsf_reg[p]       <= '0;
                fault_cnt_reg[p] <= '0;
                disk_cnt_reg[p]  <= '0;
                wb_cnt_reg[p]    <= '0;
            end
        end
        else if (fin_go && !hit_reg)
        begin
            fault_cnt_reg[cur_p_reg] <= fault_new;
            disk_cnt_reg[cur_p_reg]  <= disk_new;
            wb_cnt_reg[cur_p_reg]    <= wb_new;
            if (flush_now)
            begin
                fsf_reg[cur_p_reg] <= QUOTA_W'(1);
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if ((SPAN_W'(i) < span_reg) && (entry_owner_reg[i] == cur_p_reg))
                    begin
                        entry_valid_reg[i] <= 1'b0;
                    end
                end
            end
            else
            begin
                fsf_reg[cur_p_reg] <= fsf_inc[QUOTA_W-1:0];
            end
            if (free_ok)
            begin
                entry_valid_reg[free_sel] <= 1'b1;
                entry_owner_reg[free_sel] <= cur_p_reg;
            end
        end
    end

    // page memory write on a load
    assign ram_we          = fin_go && !hit_reg && free_ok;
    assign ram_wdata.page  = cur_page_reg;
    assign ram_wdata.dirty = cur_wr_reg;

    iptf_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH ($bits(iptf_entry_t))
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_sel),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_q)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_data_reg.hit <= hit_reg;
            if (hit_reg)
            begin
                out_data_reg.flushed          <= 1'b0;
                out_data_reg.slot             <= SLOT_W'(hit_idx_reg);
                out_data_reg.fault_total      <= fault_cnt_reg[cur_p_reg];
                out_data_reg.disk_transfers   <= disk_cnt_reg[cur_p_reg];
                out_data_reg.dirty_writebacks <= wb_cnt_reg[cur_p_reg];
            end
            else
            begin
                out_data_reg.flushed          <= flush_now;
                out_data_reg.slot             <= free_ok ? SLOT_W'(free_sel) : '0;
                out_data_reg.fault_total      <= fault_new;
                out_data_reg.disk_transfers   <= disk_new;
                out_data_reg.dirty_writebacks <= wb_new;
            end
        end
    end

    // checks on the scan and update logic
    a_cmp_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (SPAN_W'(cmp_idx_reg) < span_reg))
        else $error("compare index beyond search span");

    a_hit_keeps_table: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && hit_reg) |=> $stable(entry_valid_reg))
        else $error("hit changed the valid bits");

    a_flush_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && !hit_reg && flush_now) |=> (fsf_reg[cur_p_reg] == QUOTA_W'(1)))
        else $error("flush did not restart fault count");

    a_finish_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && out_stall) |=> (state_reg == ST_FINISH))
        else $error("finish left while output was stalled");

endmodule

/* design/iptf_ram.sv */
module iptf_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 21
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
